>>> sv/smpm_pkg.sv
package smpm_pkg;

  localparam int SMPM_CHANNELS = 32;
  localparam int SMPM_VOLUME_STEPS = 80;

  localparam int ADDR_W = 27;
  localparam int VOL_W = 16;
  localparam int IDX_W = 6;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W = 17;
  localparam int PROD_W = 18;
  localparam int SUM_W = 20;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;
  localparam logic [1:0] OP_FRAME = 2'd3;

  localparam logic [15:0] END_MARK = 16'h8000;
  localparam logic [4:0] STEREO_FIRST = 5'd30;
  localparam logic signed [SUM_W:0] SUM_MAX = 21'sd524287;
  localparam logic signed [SUM_W:0] SUM_MIN = -21'sd524288;

  // 65536 * 2^(-j/32)
  localparam logic [GAIN_W-1:0] GAIN_BASE [32] = '{
    17'd65536, 17'd64131, 17'd62757, 17'd61412, 17'd60096, 17'd58809, 17'd57548, 17'd56315,
    17'd55108, 17'd53928, 17'd52772, 17'd51641, 17'd50535, 17'd49452, 17'd48392, 17'd47355,
    17'd46340, 17'd45347, 17'd44376, 17'd43425, 17'd42494, 17'd41584, 17'd40693, 17'd39821,
    17'd38967, 17'd38132, 17'd37315, 17'd36516, 17'd35733, 17'd34968, 17'd34218, 17'd33485
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL,
    ST_DONE
  } smpm_state_t;

  typedef struct packed {
    logic addr_we;
    logic vol_we;
    logic play_we;
    logic play_val;
    logic [IDX_W-1:0] idx;
    logic [ADDR_W-1:0] addr;
    logic [VOL_W-1:0] vol;
  } smpm_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [VOL_W-1:0] vol;
    logic play;
  } smpm_rd_t;

  // gain for index i: base[(3i) mod 32] >> floor(3i/32)
  function automatic logic [GAIN_W-1:0] gain_lookup(input logic [7:0] idx);
    logic [9:0] e;
    e = {2'b00, idx} + {1'b0, idx, 1'b0};
    return GAIN_BASE[e[4:0]] >> e[9:5];
  endfunction

endpackage

>>> sv/multichannel_sample_player_mixer.sv
// multichannel sample player and stereo mixer
// input channel (in_valid / in_stall) carries one bus or sample item per transfer:
//   op 0 register write, op 1 playing-bit read, op 2 fetched sample word for a
//   voice, op 3 end of frame. every item yields exactly one result.
// output channel (out_valid / out_stall) carries the result: the echoed op and the
//   fields that belong to it (read bit, next fetch address and playing bit, or the
//   two frame sums); the other fields are zero.
// an item is taken only while the sequencer is idle. a sample item passes through the
//   lookup, the 17-step bit-serial multipliers (one gain bit per cycle, left and right
//   in parallel) and the done state before its result is loaded; other items skip the
//   multiply. the next item is taken the cycle after the result is loaded, so the input
//   takes no new item while the previous one is still in flight.
// voice state sits in small memories with a registered read; the valid bits and
//   playing flags are flip-flops.
// reset stops all voices, makes every address and volume read as zero, clears both
//   sums and empties the output register.
// while the receiver stalls, the result holds in the output register; a finished
//   item waits for it to free up and no new item is taken until then.
module multichannel_sample_player_mixer
  import smpm_pkg::*;
#(
  parameter int CHANNELS = SMPM_CHANNELS,
  parameter int VOLUME_STEPS = SMPM_VOLUME_STEPS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic [6:0]                 reg_offset,
  input  logic [31:0]                write_data,
  input  logic [4:0]                 channel,
  input  logic signed [SAMPLE_W-1:0] sample_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 result_kind,
  output logic                       status_playing,
  output logic [ADDR_W-1:0]          fetch_address,
  output logic                       channel_playing,
  output logic signed [SUM_W-1:0]    left_mix,
  output logic signed [SUM_W-1:0]    right_mix
);

  smpm_state_t state, state_next;

  logic [1:0] item_op;
  logic [6:0] item_offset;
  logic [31:0] item_data;
  logic [4:0] item_chan;
  logic signed [SAMPLE_W-1:0] item_sample;

  logic signed [SUM_W-1:0] left_sum, right_sum;
  logic signed [SUM_W-1:0] left_sum_next, right_sum_next;

  smpm_wr_t wr;
  smpm_rd_t rd;
  logic accept;
  logic rd_en;
  logic [IDX_W-1:0] rd_idx;

  logic mul_load;
  logic l_busy, r_busy;
  logic [GAIN_W-1:0] l_gain, r_gain;
  logic signed [PROD_W-1:0] l_prod, r_prod;

  logic load;
  logic ch_ok, chs_ok, is_end, mix;
  logic [IDX_W-1:0] ch;
  logic [ADDR_W-1:0] addr_step;
  logic signed [SUM_W:0] l_wide, r_wide;
  logic status_next, playing_next;
  logic [ADDR_W-1:0] fetch_next;

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign rd_en = accept;
  assign rd_idx = (op == OP_SAMPLE) ? {1'b0, channel} : reg_offset[5:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op <= op;
      item_offset <= reg_offset;
      item_data <= write_data;
      item_chan <= channel;
      item_sample <= sample_word;
    end
  end

  smpm_voice_store #(
    .CHANNELS(CHANNELS)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .rd_en(rd_en),
    .rd_idx(rd_idx),
    .wr(wr),
    .rd(rd)
  );

  // volume indices at the top of the range are muted
  always_comb begin
    l_gain = ({1'b0, rd.vol[15:8]} >= 9'(VOLUME_STEPS - 1)) ? '0 : gain_lookup(rd.vol[15:8]);
    r_gain = ({1'b0, rd.vol[7:0]} >= 9'(VOLUME_STEPS - 1)) ? '0 : gain_lookup(rd.vol[7:0]);
  end

  assign mul_load = (state == ST_LOOK) && (item_op == OP_SAMPLE);

  smpm_serial_mul u_mul_l (
    .clk(clk),
    .rst(rst),
    .load(mul_load),
    .sample(item_sample),
    .gain(l_gain),
    .busy(l_busy),
    .product(l_prod)
  );

  smpm_serial_mul u_mul_r (
    .clk(clk),
    .rst(rst),
    .load(mul_load),
    .sample(item_sample),
    .gain(r_gain),
    .busy(r_busy),
    .product(r_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ch = item_offset[5:0];
    ch_ok = {1'b0, ch} < (IDX_W + 1)'(CHANNELS);
    chs_ok = {2'b00, item_chan} < (IDX_W + 1)'(CHANNELS);
    is_end = ($unsigned(item_sample) == END_MARK);
    mix = (item_op == OP_SAMPLE) && chs_ok && rd.play && !is_end;
    addr_step = (item_chan >= STEREO_FIRST) ? ADDR_W'(2) : ADDR_W'(1);
    load = (state == ST_DONE) && (!out_valid || !out_stall);

    l_wide = {left_sum[SUM_W-1], left_sum} + (SUM_W + 1)'(l_prod);
    r_wide = {right_sum[SUM_W-1], right_sum} + (SUM_W + 1)'(r_prod);

    state_next = state;
    wr = '0;
    status_next = 1'b0;
    fetch_next = '0;
    playing_next = 1'b0;
    left_sum_next = left_sum;
    right_sum_next = right_sum;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = (item_op == OP_SAMPLE) ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        if (!l_busy && !r_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    case (item_op)
      OP_WRITE: begin
        wr.idx = ch;
        if (ch_ok && !item_offset[6]) begin
          wr.play_we = load;
          if (item_data == 32'd0) begin
            wr.play_val = 1'b0;
          end else begin
            wr.play_val = 1'b1;
            wr.addr_we = load;
            wr.addr = item_data[ADDR_W-1:0];
          end
        end else if (ch_ok) begin
          wr.vol_we = load;
          wr.vol = {item_data[23:16], item_data[7:0]};
        end
      end
      OP_READ: begin
        status_next = ch_ok && rd.play;
      end
      OP_SAMPLE: begin
        wr.idx = {1'b0, item_chan};
        if (chs_ok) begin
          fetch_next = rd.addr;
          playing_next = rd.play;
          if (rd.play && is_end) begin
            wr.play_we = load;
            wr.play_val = 1'b0;
            playing_next = 1'b0;
          end
          if (mix) begin
            fetch_next = rd.addr + addr_step;
            wr.addr_we = load;
            wr.addr = fetch_next;
            if (l_wide > SUM_MAX) begin
              left_sum_next = SUM_MAX[SUM_W-1:0];
            end else if (l_wide < SUM_MIN) begin
              left_sum_next = SUM_MIN[SUM_W-1:0];
            end else begin
              left_sum_next = l_wide[SUM_W-1:0];
            end
            if (r_wide > SUM_MAX) begin
              right_sum_next = SUM_MAX[SUM_W-1:0];
            end else if (r_wide < SUM_MIN) begin
              right_sum_next = SUM_MIN[SUM_W-1:0];
            end else begin
              right_sum_next = r_wide[SUM_W-1:0];
            end
          end
        end
      end
      OP_FRAME: begin
        left_sum_next = '0;
        right_sum_next = '0;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum <= '0;
      right_sum <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        left_sum <= left_sum_next;
        right_sum <= right_sum_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_kind <= item_op;
      status_playing <= status_next;
      fetch_address <= fetch_next;
      channel_playing <= playing_next;
      left_mix <= (item_op == OP_FRAME) ? left_sum : '0;
      right_mix <= (item_op == OP_FRAME) ? right_sum : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    (load && item_op == OP_FRAME) |=> (left_sum == '0 && right_sum == '0))
    else $error("frame transfer did not clear the sums");

  a_kind_echo: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && result_kind == $past(item_op)))
    else $error("result kind does not match the item op");

  a_mix_only_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind != OP_FRAME) |-> (left_mix == '0 && right_mix == '0))
    else $error("mix fields set on a non-frame result");

  a_mul_started: assert property (@(posedge clk) disable iff (rst)
    mul_load |=> (state == ST_MUL && l_busy && r_busy))
    else $error("serial multipliers did not start");

  a_mul_only_sample: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (item_op == OP_SAMPLE))
    else $error("multiply phase entered for a non-sample item");
`endif

endmodule

>>> sv/smpm_serial_mul.sv
module smpm_serial_mul
  import smpm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [GAIN_W-1:0]        gain,
  output logic                     busy,
  output logic signed [PROD_W-1:0] product
);

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic signed [SAMPLE_W-1:0] mcand;
  logic [GAIN_W-1:0] gsh;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] addend;
  logic signed [PROD_W-1:0] sum;
  logic [CNT_W-1:0] cnt;

  // one gain bit per cycle, lsb first; dropping the shifted-out bit keeps the floor exact
  always_comb begin
    addend = gsh[0] ? PROD_W'(mcand) : '0;
    sum = acc + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(GAIN_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mcand <= sample;
      gsh <= gain;
      acc <= '0;
    end else if (busy) begin
      gsh <= gsh >> 1;
      acc <= sum >>> 1;
    end
  end

  assign product = acc;

endmodule

>>> sv/smpm_voice_store.sv
module smpm_voice_store
  import smpm_pkg::*;
#(
  parameter int CHANNELS = SMPM_CHANNELS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  input  smpm_wr_t         wr,
  output smpm_rd_t         rd
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [ADDR_W-1:0] addr_mem [CHANNELS];
  logic [VOL_W-1:0] vol_mem [CHANNELS];
  logic [CHANNELS-1:0] addr_ok;
  logic [CHANNELS-1:0] vol_ok;
  logic [CHANNELS-1:0] play;

  logic [ADDR_W-1:0] addr_q;
  logic [VOL_W-1:0] vol_q;
  logic addr_ok_q;
  logic vol_ok_q;
  logic play_q;

  always_ff @(posedge clk) begin
    if (wr.addr_we) begin
      addr_mem[wr.idx[CH_W-1:0]] <= wr.addr;
    end
    if (wr.vol_we) begin
      vol_mem[wr.idx[CH_W-1:0]] <= wr.vol;
    end
    if (rd_en && ({1'b0, rd_idx} < (IDX_W + 1)'(CHANNELS))) begin
      addr_q <= addr_mem[rd_idx[CH_W-1:0]];
      vol_q <= vol_mem[rd_idx[CH_W-1:0]];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_ok <= '0;
      vol_ok <= '0;
      play <= '0;
      addr_ok_q <= 1'b0;
      vol_ok_q <= 1'b0;
      play_q <= 1'b0;
    end else begin
      if (wr.addr_we) begin
        addr_ok[wr.idx[CH_W-1:0]] <= 1'b1;
      end
      if (wr.vol_we) begin
        vol_ok[wr.idx[CH_W-1:0]] <= 1'b1;
      end
      if (wr.play_we) begin
        play[wr.idx[CH_W-1:0]] <= wr.play_val;
      end
      if (rd_en) begin
        if ({1'b0, rd_idx} < (IDX_W + 1)'(CHANNELS)) begin
          addr_ok_q <= addr_ok[rd_idx[CH_W-1:0]];
          vol_ok_q <= vol_ok[rd_idx[CH_W-1:0]];
          play_q <= play[rd_idx[CH_W-1:0]];
        end else begin
          addr_ok_q <= 1'b0;
          vol_ok_q <= 1'b0;
          play_q <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    rd.addr = addr_ok_q ? addr_q : '0;
    rd.vol = vol_ok_q ? vol_q : '0;
    rd.play = play_q;
  end

endmodule

>>> tb/voice_mix_checker.sv
module voice_mix_checker
  import smpm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic [6:0]                 reg_offset,
  input  logic [31:0]                write_data,
  input  logic [4:0]                 channel,
  input  logic signed [SAMPLE_W-1:0] sample_word,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 result_kind,
  input  logic                       status_playing,
  input  logic [ADDR_W-1:0]          fetch_address,
  input  logic                       channel_playing,
  input  logic signed [SUM_W-1:0]    left_mix,
  input  logic signed [SUM_W-1:0]    right_mix,
  output int                         mismatches,
  output int                         pending,
  output int                         results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]              kind;
    logic                    status;
    logic [ADDR_W-1:0]       addr;
    logic                    playing;
    logic signed [SUM_W-1:0] left;
    logic signed [SUM_W-1:0] right;
  } player_result_t;

  // floor(65536 * 2^(-j/32))
  localparam int unsigned ATTEN_STEP [32] = '{
    65536, 64131, 62757, 61412, 60096, 58809, 57548, 56315,
    55108, 53928, 52772, 51641, 50535, 49452, 48392, 47355,
    46340, 45347, 44376, 43425, 42494, 41584, 40693, 39821,
    38967, 38132, 37315, 36516, 35733, 34968, 34218, 33485
  };

  player_result_t    pending_results [$];
  logic [ADDR_W-1:0] voice_addr [SMPM_CHANNELS];
  logic              voice_on [SMPM_CHANNELS];
  logic [7:0]        vol_left [SMPM_CHANNELS];
  logic [7:0]        vol_right [SMPM_CHANNELS];
  int                frame_left;
  int                frame_right;

  function automatic int unsigned gain_for(input logic [7:0] idx);
    int unsigned e;
    if (idx >= SMPM_VOLUME_STEPS - 1) return 0;
    e = 3 * idx;
    return ATTEN_STEP[e % 32] >> (e / 32);
  endfunction

  // floor(sample * gain / 2^17)
  function automatic int scaled(input int s, input int unsigned g);
    longint p;
    p = longint'(s) * longint'(g);
    return int'(p >>> 17);
  endfunction

  function automatic int clamp_sum(input int acc, input int add);
    int s;
    s = acc + add;
    if (s > SUM_MAX) s = SUM_MAX;
    if (s < SUM_MIN) s = SUM_MIN;
    return s;
  endfunction

  function automatic player_result_t play_item(input logic [1:0] o, input logic [6:0] off,
                                               input logic [31:0] d, input logic [4:0] c,
                                               input logic signed [15:0] smp);
    player_result_t r;
    logic [5:0] v;
    int s;
    r = '{default: '0};
    r.kind = o;
    v = off[5:0];
    case (o)
      OP_WRITE: begin
        if (v < SMPM_CHANNELS) begin
          if (!off[6]) begin
            // zero data stops the voice and keeps its address
            if (d == 0) begin
              voice_on[v] = 1'b0;
            end else begin
              voice_addr[v] = d[ADDR_W-1:0];
              voice_on[v] = 1'b1;
            end
          end else begin
            vol_left[v] = d[23:16];
            vol_right[v] = d[7:0];
          end
        end
      end
      OP_READ: begin
        if (v < SMPM_CHANNELS) r.status = voice_on[v];
      end
      OP_SAMPLE: begin
        if (c < SMPM_CHANNELS) begin
          if (voice_on[c]) begin
            if (smp == END_MARK) begin
              voice_on[c] = 1'b0;
            end else begin
              s = int'(smp);
              voice_addr[c] = voice_addr[c] + ADDR_W'((c >= STEREO_FIRST) ? 2 : 1);
              frame_left = clamp_sum(frame_left, scaled(s, gain_for(vol_left[c])));
              frame_right = clamp_sum(frame_right, scaled(s, gain_for(vol_right[c])));
            end
          end
          r.addr = voice_addr[c];
          r.playing = voice_on[c];
        end
      end
      OP_FRAME: begin
        r.left = frame_left[SUM_W-1:0];
        r.right = frame_right[SUM_W-1:0];
        frame_left = 0;
        frame_right = 0;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] error: %s is %0d, should be %0d", $time, what, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    player_result_t want;
    if (rst) begin
      pending_results.delete();
      for (int i = 0; i < SMPM_CHANNELS; i++) begin
        voice_addr[i] = '0;
        voice_on[i] = 1'b0;
        vol_left[i] = '0;
        vol_right[i] = '0;
      end
      frame_left = 0;
      frame_right = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing outstanding, result_kind", result_kind, -1);
        end else begin
          want = pending_results.pop_front();
          if (result_kind !== want.kind)
            report_mismatch("result_kind", result_kind, want.kind);
          if (status_playing !== want.status)
            report_mismatch("status_playing", status_playing, want.status);
          if (fetch_address !== want.addr)
            report_mismatch("fetch_address", fetch_address, want.addr);
          if (channel_playing !== want.playing)
            report_mismatch("channel_playing", channel_playing, want.playing);
          if (left_mix !== want.left)
            report_mismatch("left_mix", longint'(left_mix), longint'(want.left));
          if (right_mix !== want.right)
            report_mismatch("right_mix", longint'(right_mix), longint'(want.right));
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(play_item(op, reg_offset, write_data, channel, sample_word));
    end
    pending = pending_results.size();
  end

endmodule

>>> tb/tb.sv
module tb
  import smpm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 820;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = '0;
  logic [6:0] reg_offset = '0;
  logic [31:0] write_data = '0;
  logic [4:0] channel = '0;
  logic signed [SAMPLE_W-1:0] sample_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] result_kind;
  logic status_playing;
  logic [ADDR_W-1:0] fetch_address;
  logic channel_playing;
  logic signed [SUM_W-1:0] left_mix;
  logic signed [SUM_W-1:0] right_mix;

  int mismatches;
  int pending;
  int results_seen;
  int cycle_count = 0;
  int send_idle_pct = 25;
  int recv_idle_pct = 50;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int samples_sent = 0;
  int frames_sent = 0;
  int bus_sent = 0;
  int sat_frames = 0;
  logic [31:0] live_voices = '0;

  always #5ns clk = ~clk;

  multichannel_sample_player_mixer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .reg_offset(reg_offset), .write_data(write_data),
    .channel(channel), .sample_word(sample_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .status_playing(status_playing),
    .fetch_address(fetch_address), .channel_playing(channel_playing),
    .left_mix(left_mix), .right_mix(right_mix)
  );

  voice_mix_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .reg_offset(reg_offset), .write_data(write_data),
    .channel(channel), .sample_word(sample_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .status_playing(status_playing),
    .fetch_address(fetch_address), .channel_playing(channel_playing),
    .left_mix(left_mix), .right_mix(right_mix),
    .mismatches(mismatches), .pending(pending), .results_seen(results_seen)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int k = 1; k < HOLD_CYCLES; k++) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [1:0] o, input logic [6:0] off, input logic [31:0] d,
                           input logic [4:0] c, input logic [15:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op <= o;
    reg_offset <= off;
    write_data <= d;
    channel <= c;
    sample_word <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    case (o)
      OP_SAMPLE: samples_sent++;
      OP_FRAME:  frames_sent++;
      default:   bus_sent++;
    endcase
  endtask

  task automatic write_reg(input logic [6:0] off, input logic [31:0] d);
    if (off[6:5] == 2'b00) live_voices[off[4:0]] = (d != 0);
    send_item(OP_WRITE, off, d, 5'($urandom), 16'($urandom));
  endtask

  task automatic read_reg(input logic [6:0] off);
    send_item(OP_READ, off, $urandom, 5'($urandom), 16'($urandom));
  endtask

  task automatic play(input logic [4:0] c, input logic [15:0] smp);
    if (smp == END_MARK) live_voices[c] = 1'b0;
    send_item(OP_SAMPLE, 7'($urandom), $urandom, c, smp);
  endtask

  task automatic end_frame();
    send_item(OP_FRAME, 7'($urandom), $urandom, 5'($urandom), 16'($urandom));
  endtask

  initial begin
    int n;
    int k;
    logic [4:0] c;
    logic [7:0] lv;
    logic [7:0] rv;
    logic [15:0] smp;
    bit loud_neg;
    bit hold1_done;
    bit hold2_done;

    hold1_done = 1'b0;
    hold2_done = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: stopped voice, address wrap, end marker, strides, muted gains,
    // voices past the last channel, empty frame
    read_reg(7'd0);
    play(5'd0, 16'h1234);
    write_reg(7'd64, 32'hAB00_CD4E);
    write_reg(7'd0, 32'hFFFF_FFFF);
    play(5'd0, 16'h7FFF);
    play(5'd0, 16'h8001);
    play(5'd0, 16'hFFFF);
    read_reg(7'd0);
    play(5'd0, END_MARK);
    read_reg(7'd0);
    write_reg(7'd95, 32'h004F_00FF);
    write_reg(7'd31, 32'h0800_0000);
    play(5'd31, 16'h4000);
    write_reg(7'd30, 32'h07FF_FFFF);
    write_reg(7'd94, 32'h0000_0000);
    play(5'd30, 16'h7FFF);
    write_reg(7'd30, 32'h0000_0000);
    play(5'd30, 16'h0100);
    write_reg(7'd63, 32'h0000_1234);
    read_reg(7'd40);
    write_reg(7'd127, 32'hFFFF_FFFF);
    read_reg(7'd31);
    end_frame();
    end_frame();

    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= 560) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= 290) begin
        send_idle_pct = 50;
        recv_idle_pct = 25;
      end
      if (!hold1_done && items_sent >= 120) begin
        hold_req = 1'b1;
        hold1_done = 1'b1;
      end
      if (!hold2_done && items_sent >= 600) begin
        hold_req = 1'b1;
        hold2_done = 1'b1;
      end

      // bus traffic between frames
      n = $urandom_range(0, 4);
      for (k = 0; k < n; k++) begin
        c = 5'($urandom_range(31));
        case ($urandom_range(9))
          0, 1: write_reg({2'b00, c}, {5'd0, 27'($urandom_range(1, 32'h7FF_FFFF))});
          2:    write_reg({2'b00, c}, {5'd0, 27'h7FF_FFFF - 27'($urandom_range(4))});
          3:    write_reg({2'b00, c}, $urandom);
          4:    write_reg({2'b00, c}, 32'h0);
          5, 6: begin
            lv = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h50));
            rv = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h50));
            write_reg({2'b10, c}, {8'($urandom), lv, 8'($urandom), rv});
          end
          7:    write_reg({1'($urandom), 1'b1, c}, $urandom);
          default: read_reg(7'($urandom));
        endcase
      end

      if ($urandom_range(9) == 0)
        send_item(2'($urandom), 7'($urandom), $urandom, 5'($urandom), 16'($urandom));

      if ($urandom_range(7) == 0) begin
        // full-scale voice at volume index 0 (the loudest gain), enough same-sign samples to hit the sum limit
        c = 5'($urandom_range(31));
        loud_neg = 1'($urandom_range(1));
        write_reg({2'b10, c}, {8'($urandom), 8'h00, 8'($urandom), 8'h00});
        write_reg({2'b00, c}, {5'd0, 27'($urandom_range(1, 32'h7FF_FFFF))});
        for (k = 0; k < 45; k++) begin
          smp = loud_neg ? 16'h8001 + 16'($urandom_range(3)) : 16'h7FFF - 16'($urandom_range(3));
          play(c, smp);
        end
        sat_frames++;
      end else begin
        n = $urandom_range(1, 34);
        for (k = 0; k < n; k++) begin
          c = 5'($urandom_range(31));
          if (live_voices != 0 && $urandom_range(9) != 0)
            while (!live_voices[c]) c = 5'($urandom_range(31));
          case ($urandom_range(19))
            0:       smp = END_MARK;
            1:       smp = 16'h7FFF;
            2:       smp = 16'h8001;
            default: smp = 16'($urandom);
          endcase
          play(c, smp);
        end
      end
      end_frame();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("covered %0d transfers: %0d samples, %0d frames (%0d pushed to the sum limits), %0d bus",
             items_sent, samples_sent, frames_sent, sat_frames, bus_sent);
    $display("%0d results compared across three idle/stall mixes and two long output holds",
             results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
